[src/tgzc_pkg.sv]
// ----------------------------------------------------------------------------
// tgzc_pkg
// Shared types, constants and the sine ROM builder for the tone generator.
// ----------------------------------------------------------------------------
package tgzc_pkg;

  // Default quarter-wave table depth
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  // Field widths
  localparam int PHASE_W  = 32;
  localparam int COUNT_W  = 24;
  localparam int SAMPLE_W = 13;
  localparam int ENTRY_W  = 16;
  localparam int FRAC_W   = 30;
  localparam int MAG_W    = 12;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_PHASE_INC   = 2'd0;
  localparam logic [1:0] REG_NOTE_LEN    = 2'd1;
  localparam logic [1:0] REG_SILENCE_LEN = 2'd2;

  // Sine arithmetic
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]        Q30_ONE     = 64'h4000_0000;
  localparam logic [ENTRY_W-1:0] TABLE_FULL  = 16'hFFFF;
  localparam int                 AMP_NUM     = 32767;
  localparam logic [63:0]        AMP_DEN     = 64'd655350;

  // Exact floor(x / 655350) for x < 2^31 as (x * MAG_RECIP) >> MAG_SHIFT
  localparam int          X_W       = 31;
  localparam int          RECIP_W   = 32;
  localparam int          PROD_W    = X_W + RECIP_W;
  localparam int          MAG_SHIFT = 51;
  localparam logic [63:0] MAG_RECIP = ((64'd1 << MAG_SHIFT) + AMP_DEN - 64'd1) / AMP_DEN;

  // Per-word control that travels down the pipeline
  typedef struct packed {
    logic restart;
    logic done;
    logic last;
    logic window;
  } tag_t;

  // One ROM entry: Q30 Taylor sine of the angle, rounded to 1/65535 units
  function automatic logic [ENTRY_W-1:0] rom_entry(input logic [63:0] ang);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] t2;
    logic [63:0] v;
    term = ang;
    sum  = ang;
    for (int n = 1; n <= 10; n++) begin
      term = (term * ang) >> 30;
      t2   = (term * ang) >> 30;
      case (n)
        1:       term = t2 / 64'd6;
        2:       term = t2 / 64'd20;
        3:       term = t2 / 64'd42;
        4:       term = t2 / 64'd72;
        5:       term = t2 / 64'd110;
        6:       term = t2 / 64'd156;
        7:       term = t2 / 64'd210;
        8:       term = t2 / 64'd272;
        9:       term = t2 / 64'd342;
        default: term = t2 / 64'd420;
      endcase
      if ((n & 1) != 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    v = (sum * 64'd65535 + (64'd1 << 29)) >> 30;
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[ENTRY_W-1:0];
  endfunction

endpackage

[src/tgzc_in_if.sv]
// ----------------------------------------------------------------------------
// tgzc_in_if
// Tick channel: one word per requested sample, carrying the restart flag.
// ----------------------------------------------------------------------------
interface tgzc_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

[src/tgzc_out_if.sv]
// ----------------------------------------------------------------------------
// tgzc_out_if
// Sample channel: one word per tick with the audio sample and note flags.
// ----------------------------------------------------------------------------
interface tgzc_out_if;
  import tgzc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_of_note;
  logic                       note_done;

  modport source (output valid, output sample, output last_of_note, output note_done,
                  input ready);
  modport sink   (input valid, input sample, input last_of_note, input note_done,
                  output ready);
endinterface

[src/tone_generator_zero_cross_mute_core.sv]
// ----------------------------------------------------------------------------
// tone_generator_zero_cross_mute_core
// Sine tone generator with end-of-note zero-crossing mute.
// ----------------------------------------------------------------------------
// Each tick word yields one sample word. The block sustains one word per clock
// while the sample side is ready; a sample passes the two-port quarter-wave
// ROM read (registered), the interpolation multiplier and the reciprocal
// multiplier that scales to one tenth of full scale before the output register.
// The phase accumulator and sample counter advance at tick acceptance;
// the zero-crossing mute state is kept at the output end, in word order. The
// ROM holds constant contents, so there is no clearing pass after reset.
// Registers sit at byte addresses 0x0 (phase increment), 0x4 (note length in
// samples) and 0x8 (silence window length); write them while the block is idle.
// ----------------------------------------------------------------------------
module tone_generator_zero_cross_mute_core #(
  parameter int SINE_TABLE_DEPTH = tgzc_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgzc_pkg::ADDR_W-1:0] paddr,
  input  logic [tgzc_pkg::DATA_W-1:0] pwdata,
  output logic [tgzc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  tgzc_in_if.sink                     tick,
  tgzc_out_if.source                  result
);
  import tgzc_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 2);
  localparam int PW = FRAC_W + IW;

  // Configuration registers
  logic [PHASE_W-1:0] phase_increment;
  logic [COUNT_W-1:0] note_samples;
  logic [COUNT_W-1:0] mute_window;

  // Note state
  logic [PHASE_W-1:0]         phase_acc;
  logic [COUNT_W-1:0]         sample_index;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic                       muted;

  // Sine ROM
  logic [ENTRY_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  // Pipeline registers
  logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
  tag_t               tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
  logic [PHASE_W-1:0] ph_s1;
  logic [ENTRY_W-1:0] rom_a, rom_b;
  logic               a_full_s2, b_full_s2, neg_s2, neg_s3, neg_s4, neg_s5;
  logic [FRAC_W-1:0]  frac_s2;
  logic [ENTRY_W-1:0] base_s3, interp_s3;
  logic [X_W-1:0]     x_s4;
  logic [MAG_W-1:0]   mag_s5;

  // Output register
  logic                       out_vld;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       out_done;

  // Stage enables
  logic en_out, en5, en4, en3, en2, en1;

  // Front-end signals
  logic               accept;
  logic [COUNT_W-1:0] i_cur;
  logic [PHASE_W-1:0] ph_cur;
  tag_t               tag_cur;

  // Stage 1 -> 2
  logic [FRAC_W:0]  r_pos;
  logic [PW-1:0]    pos;
  logic [IW-1:0]    idx, idx_nx;

  // Stage 2 -> 3
  logic [ENTRY_W-1:0]        ent_a, ent_b, diff;
  logic [ENTRY_W+FRAC_W-1:0] ip_prod;

  // Stage 3 -> 4
  logic [ENTRY_W-1:0] m_val;

  // Stage 4 -> 5
  logic [PROD_W-1:0] mag_prod;

  // End stage
  logic signed [SAMPLE_W-1:0] raw, pv;
  logic                       mu, same_pol, trig;

  // Build ROM contents from the Taylor sine at elaboration
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = rom_entry(ANGLE);
  end

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      note_samples    <= '0;
      mute_window     <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_PHASE_INC:   phase_increment <= pwdata;
        REG_NOTE_LEN:    note_samples    <= pwdata[COUNT_W-1:0];
        REG_SILENCE_LEN: mute_window     <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (paddr[3:2])
      REG_PHASE_INC:   prdata = phase_increment;
      REG_NOTE_LEN:    prdata = DATA_W'(note_samples);
      REG_SILENCE_LEN: prdata = DATA_W'(mute_window);
      default:         prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  assign en_out     = !out_vld || result.ready;
  assign en5        = !vld_s5 || en_out;
  assign en4        = !vld_s4 || en5;
  assign en3        = !vld_s3 || en4;
  assign en2        = !vld_s2 || en3;
  assign en1        = !vld_s1 || en2;
  assign tick.ready = en1;
  assign accept     = tick.valid && en1;

  // ---------------- front end: accumulator and counter ----------------
  always_comb begin
    i_cur          = tick.restart ? '0 : sample_index;
    ph_cur         = tick.restart ? '0 : phase_acc;
    tag_cur.restart = tick.restart;
    tag_cur.done    = (i_cur >= note_samples);
    tag_cur.last    = !tag_cur.done && (i_cur == note_samples - 1'b1);
    tag_cur.window  = (note_samples > mute_window) &&
                      (i_cur >= note_samples - mute_window);
  end

  // Advance phase and index, hold them past note end
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      sample_index <= '0;
    end else if (accept) begin
      phase_acc    <= tag_cur.done ? ph_cur : ph_cur + phase_increment;
      sample_index <= tag_cur.done ? i_cur : i_cur + 1'b1;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1  <= 1'b0;
      vld_s2  <= 1'b0;
      vld_s3  <= 1'b0;
      vld_s4  <= 1'b0;
      vld_s5  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (en1)    vld_s1  <= tick.valid;
      if (en2)    vld_s2  <= vld_s1;
      if (en3)    vld_s3  <= vld_s2;
      if (en4)    vld_s4  <= vld_s3;
      if (en5)    vld_s5  <= vld_s4;
      if (en_out) out_vld <= vld_s5;
    end
  end

  // Stage 1: capture phase and note flags
  always_ff @(posedge clk) begin
    if (en1) begin
      ph_s1  <= ph_cur;
      tag_s1 <= tag_cur;
    end
  end

  // ---------------- stage 2: fold quadrant, read ROM ----------------
  always_comb begin
    r_pos  = ph_s1[PHASE_W-2] ? ((FRAC_W+1)'(Q30_ONE) - {1'b0, ph_s1[FRAC_W-1:0]})
                              : {1'b0, ph_s1[FRAC_W-1:0]};
    pos    = PW'(r_pos) * PW'(SINE_TABLE_DEPTH);
    idx    = pos[PW-1:FRAC_W];
    idx_nx = idx + 1'b1;
  end

  // Two-port ROM read, registered
  always_ff @(posedge clk) begin
    if (en2) begin
      rom_a <= sine_rom[idx[AW-1:0]];
      rom_b <= sine_rom[idx_nx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      a_full_s2 <= (idx >= IW'(SINE_TABLE_DEPTH));
      b_full_s2 <= (idx_nx >= IW'(SINE_TABLE_DEPTH));
      frac_s2   <= pos[FRAC_W-1:0];
      neg_s2    <= ph_s1[PHASE_W-1];
      tag_s2    <= tag_s1;
    end
  end

  // ---------------- stage 3: interpolate between entries ----------------
  always_comb begin
    ent_a   = a_full_s2 ? TABLE_FULL : rom_a;
    ent_b   = b_full_s2 ? TABLE_FULL : rom_b;
    diff    = (ent_b > ent_a) ? ent_b - ent_a : '0;
    ip_prod = (ENTRY_W+FRAC_W)'(diff) * (ENTRY_W+FRAC_W)'(frac_s2);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      base_s3   <= ent_a;
      interp_s3 <= ip_prod[ENTRY_W+FRAC_W-1:FRAC_W];
      neg_s3    <= neg_s2;
      tag_s3    <= tag_s2;
    end
  end

  // ---------------- stage 4: scale numerator ----------------
  assign m_val = base_s3 + interp_s3;

  always_ff @(posedge clk) begin
    if (en4) begin
      x_s4   <= X_W'(m_val) * X_W'(AMP_NUM);
      neg_s4 <= neg_s3;
      tag_s4 <= tag_s3;
    end
  end

  // ---------------- stage 5: divide by reciprocal ----------------
  assign mag_prod = PROD_W'(x_s4) * PROD_W'(MAG_RECIP[RECIP_W-1:0]);

  always_ff @(posedge clk) begin
    if (en5) begin
      mag_s5 <= mag_prod[PROD_W-1:MAG_SHIFT];
      neg_s5 <= neg_s4;
      tag_s5 <= tag_s4;
    end
  end

  // ---------------- end stage: sign, zero-crossing mute ----------------
  always_comb begin
    raw      = neg_s5 ? -SAMPLE_W'(mag_s5) : SAMPLE_W'(mag_s5);
    pv       = tag_s5.restart ? '0 : prev_sample;
    mu       = tag_s5.restart ? 1'b0 : muted;
    same_pol = ((pv < 0) && (raw < 0)) || ((pv > 0) && (raw > 0));
    trig     = !mu && tag_s5.window && !same_pol;
  end

  // Update mute state in word order
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      muted       <= 1'b0;
    end else if (en_out && vld_s5) begin
      if (tag_s5.done) begin
        prev_sample <= pv;
        muted       <= mu;
      end else begin
        prev_sample <= raw;
        muted       <= mu || trig;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (en_out && vld_s5) begin
      out_sample <= (tag_s5.done || mu || trig) ? '0 : raw;
      out_last   <= tag_s5.last;
      out_done   <= tag_s5.done;
    end
  end

  assign result.valid        = out_vld;
  assign result.sample       = out_sample;
  assign result.last_of_note = out_last;
  assign result.note_done    = out_done;

endmodule

[tb/tgzc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgzc_checker
// Watches the tick, sample and register channels of the tone generator. It
// tracks the register writes, predicts every sample word from its own model
// of the phase accumulator, the quarter-wave sine table and the end-of-note
// mute, and compares each sample word with the oldest prediction.
// ----------------------------------------------------------------------------
module tgzc_checker #(
  parameter int DEPTH = tgzc_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgzc_pkg::ADDR_W-1:0] paddr,
  input  logic [tgzc_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  tgzc_in_if                          tick,
  tgzc_out_if                         result,
  output int unsigned                 pending,
  output int unsigned                 fails
);
  import tgzc_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_note;
    logic                       note_done;
  } tone_word_t;

  // Quarter-wave table, built once
  logic [ENTRY_W-1:0] quarter_rom [DEPTH];

  // Register copies
  logic [PHASE_W-1:0] phase_step;
  logic [COUNT_W-1:0] note_len;
  logic [COUNT_W-1:0] window_len;

  // Note state
  logic        [PHASE_W-1:0]  acc;
  logic        [COUNT_W-1:0]  position;
  logic signed [SAMPLE_W-1:0] last_raw;
  logic                       mute_on;

  tone_word_t  expected_words [$];
  int unsigned mismatch_total;

  // Q30 Taylor sine of entry k's angle, rounded to units of 1/65535
  function automatic logic [ENTRY_W-1:0] taylor_rom_entry(input int unsigned k);
    logic [63:0] ang;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    ang  = (HALF_PI_Q30 * 64'(k)) / 64'(DEPTH);
    term = ang;
    sum  = ang;
    for (int n = 1; n <= 10; n++) begin
      term = (term * ang) >> 30;
      term = ((term * ang) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    v = (sum * 64'd65535 + (64'd1 << 29)) >> 30;
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[ENTRY_W-1:0];
  endfunction

  // Entries past the table read as full scale
  function automatic logic [ENTRY_W-1:0] rom_at(input logic [63:0] k);
    return (k < 64'(DEPTH)) ? quarter_rom[k] : TABLE_FULL;
  endfunction

  // Interpolated sine at one tenth of full scale, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] sine_value(input logic [PHASE_W-1:0] phase);
    logic [1:0]                 quad;
    logic [63:0]                r;
    logic [63:0]                pos;
    logic [63:0]                slot;
    logic [63:0]                frac;
    logic [ENTRY_W-1:0]         a;
    logic [ENTRY_W-1:0]         b;
    logic [63:0]                m;
    logic [63:0]                mag;
    logic signed [SAMPLE_W-1:0] s;
    quad = phase[31:30];
    r    = {34'd0, phase[29:0]};
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    pos  = r * 64'(DEPTH);
    slot = pos >> 30;
    frac = pos & (Q30_ONE - 64'd1);
    a    = rom_at(slot);
    b    = rom_at(slot + 64'd1);
    m    = 64'(a);
    if (b > a) begin
      m = 64'(a) + ((64'(b - a) * frac) >> 30);
    end
    mag = (m * 64'(AMP_NUM)) / AMP_DEN;
    s   = mag[SAMPLE_W-1:0];
    if (quad[1]) begin
      s = -s;
    end
    return s;
  endfunction

  // Produce the next sample word and advance the note
  task automatic next_tone_word(input logic restart, output tone_word_t w);
    logic signed [SAMPLE_W-1:0] raw;
    logic                       polarity_kept;
    if (restart) begin
      acc      = '0;
      position = '0;
      last_raw = '0;
      mute_on  = 1'b0;
    end
    w = '0;
    if (position >= note_len) begin
      // past the end: silent, flagged, state held
      w.note_done = 1'b1;
    end else begin
      raw           = sine_value(acc);
      polarity_kept = (last_raw < 0 && raw < 0) || (last_raw > 0 && raw > 0);
      w.sample      = raw;
      if (mute_on) begin
        w.sample = '0;
      end else if (note_len > window_len && position >= note_len - window_len &&
                   !polarity_kept) begin
        mute_on  = 1'b1;
        w.sample = '0;
      end
      w.last_of_note = (position == note_len - 24'd1);
      last_raw = raw;
      acc      = acc + phase_step;
      position = position + 24'd1;
    end
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      quarter_rom[k] = taylor_rom_entry(k);
    end
  end

  // Track registers, predict on ticks, compare on samples
  always @(posedge clk) begin
    tone_word_t want;
    tone_word_t got;
    if (rst) begin
      phase_step     = '0;
      note_len       = '0;
      window_len     = '0;
      acc            = '0;
      position       = '0;
      last_raw       = '0;
      mute_on        = 1'b0;
      mismatch_total = 0;
      expected_words.delete();
      pending <= 0;
      fails   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_PHASE_INC:   phase_step = pwdata[PHASE_W-1:0];
          REG_NOTE_LEN:    note_len   = pwdata[COUNT_W-1:0];
          REG_SILENCE_LEN: window_len = pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (tick.valid && tick.ready) begin
        next_tone_word(tick.restart, want);
        expected_words.push_back(want);
      end

      if (result.valid && result.ready) begin
        got.sample       = result.sample;
        got.last_of_note = result.last_of_note;
        got.note_done    = result.note_done;
        if (expected_words.size() == 0) begin
          if (mismatch_total < 100) begin
            $display("%0t: unexpected sample word: expected none, actual %0d/%0b/%0b",
                     $time, got.sample, got.last_of_note, got.note_done);
          end
          mismatch_total++;
        end else begin
          want = expected_words.pop_front();
          if (got.sample !== want.sample) begin
            if (mismatch_total < 100) begin
              $display("%0t: sample mismatch: expected %0d, actual %0d",
                       $time, want.sample, got.sample);
            end
            mismatch_total++;
          end
          if (got.last_of_note !== want.last_of_note) begin
            if (mismatch_total < 100) begin
              $display("%0t: last_of_note mismatch: expected %0b, actual %0b",
                       $time, want.last_of_note, got.last_of_note);
            end
            mismatch_total++;
          end
          if (got.note_done !== want.note_done) begin
            if (mismatch_total < 100) begin
              $display("%0t: note_done mismatch: expected %0b, actual %0b",
                       $time, want.note_done, got.note_done);
            end
            mismatch_total++;
          end
        end
      end

      pending <= expected_words.size();
      fails   <= mismatch_total;
    end
  end

endmodule

[tb/tone_generator_zero_cross_mute_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_generator_zero_cross_mute_core_tb
// Drives tick words and register writes into the tone generator, stalls the
// sample side at random and with long hold-offs, and gives the verdict from
// the checker's mismatch count once every predicted sample word has arrived.
// ----------------------------------------------------------------------------
module tone_generator_zero_cross_mute_core_tb;
  import tgzc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int TOTAL_WORDS  = 1430;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tgzc_in_if  tick_bus ();
  tgzc_out_if sample_bus ();

  int unsigned pending;
  int unsigned fails;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  int unsigned hold_req = 0;
  int unsigned hold_done = 0;
  logic        calm = 1'b0;

  tone_generator_zero_cross_mute_core #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH_DEF)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tick    (tick_bus),
    .result  (sample_bus)
  );

  tgzc_checker #(
    .DEPTH(SINE_TABLE_DEPTH_DEF)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .tick    (tick_bus),
    .result  (sample_bus),
    .pending (pending),
    .fails   (fails)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tone_generator_zero_cross_mute_core test failed");
      $finish;
    end
  end

  // Sample side: random stalls, a long hold-off on request
  initial begin
    sample_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done < hold_req) begin
        sample_bus.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          @(posedge clk);
        end
        hold_done = hold_done + 1;
      end else begin
        sample_bus.ready <= calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Start one register write; lower the bus after the last one
  task automatic write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value,
                           input bit last);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (last) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  task automatic set_tone(input logic [31:0] step, input logic [23:0] len,
                          input logic [23:0] window);
    write_reg(REG_PHASE_INC, step, 1'b0);
    write_reg(REG_NOTE_LEN, {8'd0, len}, 1'b0);
    write_reg(REG_SILENCE_LEN, {8'd0, window}, 1'b1);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic settle();
    tick_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Send tick words; restart every period words and at random
  task automatic play(input bit first_restart, input int count, input int period,
                      input int pct);
    bit r;
    for (int k = 0; k < count; k++) begin
      if (k == 0) begin
        r = first_restart;
      end else begin
        r = (period != 0 && (k % period) == 0) || ($urandom_range(0, 99) < pct);
      end
      if (!calm && $urandom_range(0, 99) < 25) begin
        tick_bus.valid   <= 1'b0;
        tick_bus.restart <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      tick_bus.valid   <= 1'b1;
      tick_bus.restart <= r;
      @(posedge clk);
      while (!tick_bus.ready) @(posedge clk);
      sent++;
    end
  endtask

  initial begin
    logic [31:0] step;
    logic [23:0] len;
    logic [23:0] window;
    int          count;
    int          period;
    int          phase;
    int          pick;

    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    tick_bus.valid   <= 1'b0;
    tick_bus.restart <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Quarter-turn steps: peaks, zeros, mute on the first window word, end of note
    set_tone(32'h4000_0000, 24'd8, 24'd3);
    play(1'b1, 11, 0, 0);
    settle();
    // Empty note at the widest step
    set_tone(32'hFFFF_FFFF, 24'd0, 24'd0);
    play(1'b1, 3, 0, 0);
    settle();
    // Window as long as the note: no mute search
    set_tone(32'h0000_0000, 24'd5, 24'd5);
    play(1'b1, 6, 0, 0);
    settle();
    // Half-turn steps: raw zeros inside the window
    set_tone(32'h8000_0000, 24'd6, 24'd2);
    play(1'b1, 6, 0, 0);
    settle();
    // Longest note and window, then a step change in the middle of the note
    set_tone(32'h1234_5678, 24'hFF_FFFF, 24'hFF_FFFF);
    play(1'b1, 3, 0, 0);
    settle();
    write_reg(REG_PHASE_INC, 32'h0800_0000, 1'b1);
    play(1'b0, 2, 0, 0);

    // Random notes, mostly short and restarted at their ends
    phase = 0;
    while (sent < TOTAL_WORDS) begin
      settle();
      calm <= (phase == 4);
      if (phase == 2 || phase == 9) begin
        hold_req <= hold_req + 1;
      end

      pick = $urandom_range(0, 9);
      case (pick)
        0:       step = 32'h0;
        1:       step = 32'hFFFF_FFFF;
        2:       step = $urandom_range(1, 1 << 20);
        default: step = $urandom;
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0:       len = 24'd0;
        1:       len = 24'hFF_FFFF;
        2:       len = 24'($urandom);
        default: len = 24'($urandom_range(1, 150));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0:       window = 24'd0;
        1:       window = 24'hFF_FFFF;
        2:       window = 24'($urandom);
        3:       window = len - 24'($urandom_range(0, 20));
        default: window = 24'($urandom_range(0, 60));
      endcase

      // Now and then change only the step and carry on the current note
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_PHASE_INC, step, 1'b1);
      end else begin
        set_tone(step, len, window);
      end

      period = (len != 0 && len <= 200) ? int'(len) + $urandom_range(0, 3) : 0;
      count  = (phase == 4) ? 200 : $urandom_range(20, 160);
      play($urandom_range(0, 3) != 0, count, period, 2);
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tone_generator_zero_cross_mute_core test passed");
    end else begin
      $display("tone_generator_zero_cross_mute_core test failed");
    end
    $finish;
  end

endmodule
